// ===== rtl/core/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and helpers shared by the Playfair digraph encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned SIDE       = 5;
  localparam int unsigned CELLS      = SIDE * SIDE;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CFG_DATA_W = 50;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef letter_t [CELLS-1:0] square_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_TOP = 2'd0,
    CFG_ROWS_MID = 2'd1,
    CFG_ROW_LAST = 2'd2,
    CFG_FILLER   = 2'd3
  } cfg_reg_t;

  localparam letter_t LETTER_I      = 5'd8;
  localparam letter_t LETTER_J      = 5'd9;
  localparam letter_t FILLER_RESET  = 5'd23;
  localparam pos_t    POS_LAST      = 3'd4;

  // Where a letter sits in the square
  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } locate_t;

  function automatic letter_t fold_j(letter_t c);
    return (c == LETTER_J) ? LETTER_I : c;
  endfunction

  // Wrap a row or column position to the next one
  function automatic pos_t pos_inc(pos_t p);
    return (p == POS_LAST) ? '0 : p + 3'd1;
  endfunction

  // Square entry at row r, column c (both below SIDE)
  function automatic letter_t cell_at(square_t sq, pos_t r, pos_t c);
    logic [IDX_W-1:0] idx;
    idx = ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    return sq[idx];
  endfunction

endpackage

// ===== rtl/core/pfe_pair_if.sv =====
// ----------------------------------------------------------------------------
// pfe_pair_if
// Plaintext digraph channel: valid/ready with two letter codes.
// ----------------------------------------------------------------------------
interface pfe_pair_if;
  logic       valid;
  logic       ready;
  logic [4:0] first_letter;
  logic [4:0] second_letter;

  modport source (output valid, output first_letter, output second_letter, input ready);
  modport sink   (input valid, input first_letter, input second_letter, output ready);
endinterface

// ===== rtl/core/pfe_cipher_if.sv =====
// ----------------------------------------------------------------------------
// pfe_cipher_if
// Cipher digraph channel: valid/ready with two letter codes and a miss flag.
// ----------------------------------------------------------------------------
interface pfe_cipher_if;
  logic       valid;
  logic       ready;
  logic [4:0] cipher_first;
  logic [4:0] cipher_second;
  logic       not_in_square;

  modport source (output valid, output cipher_first, output cipher_second,
                  output not_in_square, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second,
                  input not_in_square, output ready);
endinterface

// ===== rtl/core/pfe_locate.sv =====
// ----------------------------------------------------------------------------
// pfe_locate
// Finds the row and column of a letter in the key square, first match wins.
// ----------------------------------------------------------------------------
module pfe_locate
  import pfe_pkg::*;
(
  input  square_t square,
  input  letter_t letter,
  output locate_t pos
);

  logic [CELLS-1:0] hit;

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      hit[i] = (square[i] == letter);
    end
  end

  // Scan from the last cell down so the lowest matching cell is kept
  always_comb begin
    pos = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (hit[r * SIDE + c]) begin
          pos.found = 1'b1;
          pos.row   = POS_W'(r);
          pos.col   = POS_W'(c);
        end
      end
    end
  end

endmodule

// ===== rtl/core/playfair_digraph_encrypt.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// Playfair encryption of one digraph per transaction with a 5x5 key square.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  pair_in     in   valid/ready    first_letter, second_letter
//  cipher_out  out  valid/ready    cipher_first, cipher_second, not_in_square
//  cfg         in   cfg_we         cfg_index, cfg_data (50 bits)
//
//  Two register stages: input register, then result register.
//  One transaction per cycle sustained while the output is not stalled; the
//  square lookup and substitution sit between the two registers. A stalled
//  output holds the result register and backs up the input register. Reset
//  clears the valid bits and the key square, and sets the filler to X.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt
  import pfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pfe_pair_if.sink              pair_in,
  pfe_cipher_if.source          cipher_out
);

  // Configuration
  logic [49:0] square_rows_top;
  logic [49:0] square_rows_mid;
  logic [24:0] square_row_last;
  letter_t     filler_letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_rows_top <= '0;
      square_rows_mid <= '0;
      square_row_last <= '0;
      filler_letter   <= FILLER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROWS_TOP: square_rows_top <= cfg_data;
        CFG_ROWS_MID: square_rows_mid <= cfg_data;
        CFG_ROW_LAST: square_row_last <= cfg_data[24:0];
        CFG_FILLER:   filler_letter   <= cfg_data[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  square_t square;
  assign square = {square_row_last, square_rows_mid, square_rows_top};

  // Input register
  logic    in_valid;
  letter_t in_first;
  letter_t in_second;
  logic    out_valid;
  logic    in_move;

  assign in_move       = in_valid && (!out_valid || cipher_out.ready);
  assign pair_in.ready = !in_valid || in_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pair_in.ready) begin
      in_valid <= pair_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_in.valid && pair_in.ready) begin
      in_first  <= pair_in.first_letter;
      in_second <= pair_in.second_letter;
    end
  end

  // Substitution
  letter_t p;
  letter_t q_raw;
  letter_t q;
  locate_t loc_p;
  locate_t loc_q;

  assign p     = fold_j(in_first);
  assign q_raw = fold_j(in_second);
  assign q     = (p == q_raw) ? fold_j(filler_letter) : q_raw;

  pfe_locate u_locate_p (.square(square), .letter(p), .pos(loc_p));
  pfe_locate u_locate_q (.square(square), .letter(q), .pos(loc_q));

  letter_t c1_next;
  letter_t c2_next;
  logic    miss_next;

  always_comb begin
    miss_next = !(loc_p.found && loc_q.found);
    if (miss_next) begin
      c1_next = '0;
      c2_next = '0;
    end else if (loc_p.row == loc_q.row) begin
      c1_next = cell_at(square, loc_p.row, pos_inc(loc_p.col));
      c2_next = cell_at(square, loc_q.row, pos_inc(loc_q.col));
    end else if (loc_p.col == loc_q.col) begin
      c1_next = cell_at(square, pos_inc(loc_p.row), loc_p.col);
      c2_next = cell_at(square, pos_inc(loc_q.row), loc_q.col);
    end else begin
      c1_next = cell_at(square, loc_p.row, loc_q.col);
      c2_next = cell_at(square, loc_q.row, loc_p.col);
    end
  end

  // Result register
  letter_t cipher_first;
  letter_t cipher_second;
  logic    not_in_square;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_move) begin
      out_valid <= 1'b1;
    end else if (cipher_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      cipher_first  <= c1_next;
      cipher_second <= c2_next;
      not_in_square <= miss_next;
    end
  end

  assign cipher_out.valid         = out_valid;
  assign cipher_out.cipher_first  = cipher_first;
  assign cipher_out.cipher_second = cipher_second;
  assign cipher_out.not_in_square = not_in_square;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_in_square |-> cipher_first == '0 && cipher_second == '0)
    else $error("miss result carries nonzero letters");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    pair_in.valid && pair_in.ready |=> in_valid)
    else $error("accepted transaction not held in input register");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !cipher_out.ready |-> !pair_in.ready)
    else $error("input taken while both stages are stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !in_valid && !out_valid)
    else $error("stages not empty after reset");
`endif

endmodule
